// ===== sv/arc_pkg.sv =====
// Shared types and constants for the access rule table checker.
`timescale 1ns / 1ps

package arc_pkg;

    // Default table geometry.
    localparam int RULE_ENTRIES_DEF = 64;
    localparam int EXTRA_GROUPS_DEF = 4;

    // Number of supplementary group ports on the input channel.
    localparam int EXTRA_GROUP_PORTS = 4;

    // Item operation codes.
    localparam logic CMD_CHECK  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One stored rule, also used for the request under check.
    typedef struct packed {
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic [31:0] command;
        logic [31:0] user;
        logic [31:0] group;
    } rule_t;

    // Token that walks the cell chain during a check.
    typedef struct packed {
        logic active;
        logic seen;
        logic allow;
    } token_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPLY
    } state_t;

endpackage

// ===== sv/arc_rule_cell.sv =====
// One rule cell: holds a stored rule and matches the passing check token against it.
`timescale 1ns / 1ps

module arc_rule_cell #(
    parameter int EXTRA_GROUPS = arc_pkg::EXTRA_GROUPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  arc_pkg::rule_t                     wr_rule,
    input  arc_pkg::rule_t                     q_rule,
    input  logic [EXTRA_GROUPS-1:0][31:0]      q_extra,
    input  logic [EXTRA_GROUPS-1:0]            q_extra_mask,
    input  arc_pkg::token_t                    tok_in,
    output arc_pkg::token_t                    tok_out
);

    logic            valid_reg;
    arc_pkg::rule_t  rule_reg;
    arc_pkg::token_t tok_reg;
    arc_pkg::token_t tok_next;
    logic            hit;
    logic            in_group;
    logic            grant;

    // The valid bit and the token register are the only stored state that reset clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= 1'b1;
        end
    end

    // Rule contents are loaded once when the cell is filled.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rule_reg <= wr_rule;
        end
    end

    // Match the request against this rule and fold the outcome into the token.
    always_comb begin
        hit = valid_reg
            && (rule_reg.uuid_high == q_rule.uuid_high)
            && (rule_reg.uuid_low == q_rule.uuid_low)
            && (rule_reg.command == q_rule.command);
        in_group = (rule_reg.group == q_rule.group);
        for (int k = 0; k < EXTRA_GROUPS; k++) begin
            if (q_extra_mask[k] && (q_extra[k] == rule_reg.group)) begin
                in_group = 1'b1;
            end
        end
        grant = hit && ((rule_reg.user == q_rule.user) || in_group);

        tok_next.active = tok_in.active;
        tok_next.seen   = tok_in.active && (tok_in.seen || hit);
        tok_next.allow  = tok_in.active && (tok_in.allow || grant);
    end

    // Hand the token to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/access_rule_table_checker_core.sv =====
// Top level of the access rule table checker: sequencer, fill pointer and the rule cell chain.
`timescale 1ns / 1ps
// Result path: an insert, or a check with override set, goes from the input transfer to the
// REPLY state and is then registered onto the result channel once the output is free; any
// other check first walks a token through the rule cell chain, one rule cell per cycle,
// before REPLY. Throughput: one item at a time; the input closes until the result is out.
// Reset: synchronous, active low; clears all cell valid bits, the fill count and
// strict_mode at once, so the block accepts items in the first cycle after reset.

module access_rule_table_checker_core #(
    parameter int RULE_ENTRIES = arc_pkg::RULE_ENTRIES_DEF,
    parameter int EXTRA_GROUPS = arc_pkg::EXTRA_GROUPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [63:0] s_uuid_high,
    input  logic [63:0] s_uuid_low,
    input  logic [31:0] s_command_code,
    input  logic [31:0] s_user_id,
    input  logic [31:0] s_group_id,
    input  logic        s_override,
    input  logic [2:0]  s_group_count,
    input  logic [31:0] s_extra_group_a,
    input  logic [31:0] s_extra_group_b,
    input  logic [31:0] s_extra_group_c,
    input  logic [31:0] s_extra_group_d,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_permitted,
    output logic        m_status
);

    localparam int IDX_W  = $clog2(RULE_ENTRIES);
    localparam int FILL_W = $clog2(RULE_ENTRIES + 1);

    arc_pkg::state_t state_reg, state_next;

    logic              strict_mode_reg;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic              start_reg, start_next;
    logic              pend_permitted_reg, pend_permitted_next;
    logic              pend_status_reg, pend_status_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_permitted_reg, m_permitted_next;
    logic              m_status_reg, m_status_next;

    arc_pkg::rule_t                q_rule_reg;
    logic [EXTRA_GROUPS-1:0][31:0] q_extra_reg;
    logic [EXTRA_GROUPS-1:0]       q_extra_mask_reg;

    logic [arc_pkg::EXTRA_GROUP_PORTS-1:0][31:0] s_extra_all;
    logic [EXTRA_GROUPS-1:0][31:0]               s_extra;
    logic [EXTRA_GROUPS-1:0]                     s_extra_mask;

    arc_pkg::rule_t    s_rule;
    logic              accept;
    logic              load_query;
    logic              ins_wr;
    logic              table_full;
    logic              out_free;
    logic [IDX_W-1:0]  fill_idx;
    logic [RULE_ENTRIES-1:0] wr_sel;

    arc_pkg::token_t   tok [RULE_ENTRIES+1];

    // Request fields gathered from the input ports.
    assign s_rule.uuid_high = s_uuid_high;
    assign s_rule.uuid_low  = s_uuid_low;
    assign s_rule.command   = s_command_code;
    assign s_rule.user      = s_user_id;
    assign s_rule.group     = s_group_id;

    assign s_extra_all[0] = s_extra_group_a;
    assign s_extra_all[1] = s_extra_group_b;
    assign s_extra_all[2] = s_extra_group_c;
    assign s_extra_all[3] = s_extra_group_d;

    // Keep the first EXTRA_GROUPS supplementary groups; the count saturates implicitly.
    always_comb begin
        for (int k = 0; k < EXTRA_GROUPS; k++) begin
            s_extra[k]      = s_extra_all[k];
            s_extra_mask[k] = (s_group_count > 3'(k));
        end
    end

    assign s_ready    = (state_reg == arc_pkg::ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign table_full = (fill_count_reg == FILL_W'(RULE_ENTRIES));
    assign fill_idx   = fill_count_reg[IDX_W-1:0];
    assign out_free   = !m_valid_reg || m_ready;
    assign ins_wr     = accept && (s_cmd == arc_pkg::CMD_INSERT) && !table_full;
    assign load_query = accept && (s_cmd == arc_pkg::CMD_CHECK) && !s_override;

    // Write select: the cell at the fill pointer takes the new rule.
    always_comb begin
        for (int i = 0; i < RULE_ENTRIES; i++) begin
            wr_sel[i] = ins_wr && (fill_idx == IDX_W'(i));
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            strict_mode_reg <= cfg_wdata;
        end
    end

    // Request under check, held for the whole scan.
    always_ff @(posedge aclk) begin
        if (load_query) begin
            q_rule_reg       <= s_rule;
            q_extra_reg      <= s_extra;
            q_extra_mask_reg <= s_extra_mask;
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= arc_pkg::ST_IDLE;
            fill_count_reg <= '0;
            start_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            start_reg      <= start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        pend_permitted_reg <= pend_permitted_next;
        pend_status_reg    <= pend_status_next;
        m_permitted_reg    <= m_permitted_next;
        m_status_reg       <= m_status_next;
    end

    // Sequencer: next state, fill pointer and result handling.
    always_comb begin
        state_next          = state_reg;
        fill_count_next     = fill_count_reg;
        start_next          = 1'b0;
        pend_permitted_next = pend_permitted_reg;
        pend_status_next    = pend_status_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_permitted_next    = m_permitted_reg;
        m_status_next       = m_status_reg;

        unique case (state_reg)
            arc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == arc_pkg::CMD_INSERT) begin
                        pend_permitted_next = 1'b0;
                        pend_status_next    = table_full ? arc_pkg::STATUS_FULL
                                                         : arc_pkg::STATUS_OK;
                        if (!table_full) begin
                            fill_count_next = fill_count_reg + FILL_W'(1);
                        end
                        state_next = arc_pkg::ST_REPLY;
                    end else if (s_override) begin
                        pend_permitted_next = 1'b1;
                        pend_status_next    = arc_pkg::STATUS_OK;
                        state_next          = arc_pkg::ST_REPLY;
                    end else begin
                        start_next = 1'b1;
                        state_next = arc_pkg::ST_SCAN;
                    end
                end
            end
            arc_pkg::ST_SCAN: begin
                // The token leaving the last cell carries the verdict of the whole table.
                if (tok[RULE_ENTRIES].active) begin
                    pend_permitted_next = tok[RULE_ENTRIES].seen ? tok[RULE_ENTRIES].allow
                                                                 : !strict_mode_reg;
                    pend_status_next    = arc_pkg::STATUS_OK;
                    state_next          = arc_pkg::ST_REPLY;
                end
            end
            arc_pkg::ST_REPLY: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_permitted_next = pend_permitted_reg;
                    m_status_next    = pend_status_reg;
                    state_next       = arc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = arc_pkg::ST_IDLE;
            end
        endcase
    end

    // Token injected at the head of the chain.
    assign tok[0].active = start_reg;
    assign tok[0].seen   = 1'b0;
    assign tok[0].allow  = 1'b0;

    // The chain of rule cells.
    for (genvar i = 0; i < RULE_ENTRIES; i++) begin : g_cell
        arc_rule_cell #(
            .EXTRA_GROUPS (EXTRA_GROUPS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .wr_en        (wr_sel[i]),
            .wr_rule      (s_rule),
            .q_rule       (q_rule_reg),
            .q_extra      (q_extra_reg),
            .q_extra_mask (q_extra_mask_reg),
            .tok_in       (tok[i]),
            .tok_out      (tok[i+1])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_permitted = m_permitted_reg;
    assign m_status    = m_status_reg;

endmodule

// ===== sv/arc_checker.sv =====
// Port-level checker for the access rule table checker, bound to the top level.
`timescale 1ns / 1ps

module arc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_permitted,
    input logic m_status
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_permitted) && $stable(m_status))
        else $error("result changed while stalled");

    // One item at a time: the input closes right after a transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after a transfer");

    // A refused insert never reports a permit.
    a_full_denies: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_status && m_permitted))
        else $error("full status together with permit");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind access_rule_table_checker_core arc_checker u_arc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_permitted (m_permitted),
    .m_status    (m_status)
);

// ===== tb/tb.sv =====
// Testbench for access_rule_table_checker_core: directed and random traffic checked against a local model.
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH = arc_pkg::RULE_ENTRIES_DEF;
    localparam int GROUP_SLOTS = arc_pkg::EXTRA_GROUPS_DEF;
    // A full table scan plus the reply stage.
    localparam int SCAN_CYCLES = TABLE_DEPTH + 2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 420;

    // One request on the input channel.
    typedef struct packed {
        logic        op;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic [31:0] command_code;
        logic [31:0] user_id;
        logic [31:0] group_id;
        logic        override;
        logic [2:0]  group_count;
        logic [31:0] extra_a;
        logic [31:0] extra_b;
        logic [31:0] extra_c;
        logic [31:0] extra_d;
    } access_req_t;

    // One decision on the result channel.
    typedef struct packed {
        logic permitted;
        logic status;
    } decision_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    access_req_t s_req;
    logic        m_valid;
    logic        m_ready;
    logic        m_permitted;
    logic        m_status;

    // Local copy of the rule table and the policy register.
    logic [63:0] rule_uuid_high [TABLE_DEPTH];
    logic [63:0] rule_uuid_low [TABLE_DEPTH];
    logic [31:0] rule_command [TABLE_DEPTH];
    logic [31:0] rule_user [TABLE_DEPTH];
    logic [31:0] rule_group [TABLE_DEPTH];
    int unsigned rule_count;
    logic        strict_deny;

    // Value pools that make rule keys and caller ids collide often.
    logic [63:0] uuid_pool_high [8];
    logic [63:0] uuid_pool_low [8];
    logic [31:0] command_pool [4];
    logic [31:0] id_pool [8];

    decision_t   expected_decisions [$];
    int          fail_count;
    int          cycle_count;
    logic        input_gaps_on;
    logic        output_stalls_on;

    always #2 aclk = ~aclk;

    access_rule_table_checker_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_req.op),
        .s_uuid_high     (s_req.uuid_high),
        .s_uuid_low      (s_req.uuid_low),
        .s_command_code  (s_req.command_code),
        .s_user_id       (s_req.user_id),
        .s_group_id      (s_req.group_id),
        .s_override      (s_req.override),
        .s_group_count   (s_req.group_count),
        .s_extra_group_a (s_req.extra_a),
        .s_extra_group_b (s_req.extra_b),
        .s_extra_group_c (s_req.extra_c),
        .s_extra_group_d (s_req.extra_d),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_permitted     (m_permitted),
        .m_status        (m_status)
    );

    // Applies one request to the local table and returns the decision it should produce.
    function automatic decision_t decide_access(input access_req_t req);
        decision_t   d;
        logic [31:0] extras [GROUP_SLOTS];
        int unsigned n_extra;
        logic        seen;
        logic        allow;
        extras[0] = req.extra_a;
        extras[1] = req.extra_b;
        extras[2] = req.extra_c;
        extras[3] = req.extra_d;
        d.permitted = 1'b0;
        d.status = arc_pkg::STATUS_OK;
        n_extra = (req.group_count > GROUP_SLOTS) ? GROUP_SLOTS : req.group_count;
        if (req.op == arc_pkg::CMD_INSERT) begin
            if (rule_count >= TABLE_DEPTH) begin
                d.status = arc_pkg::STATUS_FULL;
            end else begin
                rule_uuid_high[rule_count] = req.uuid_high;
                rule_uuid_low[rule_count] = req.uuid_low;
                rule_command[rule_count] = req.command_code;
                rule_user[rule_count] = req.user_id;
                rule_group[rule_count] = req.group_id;
                rule_count++;
            end
            return d;
        end
        if (req.override) begin
            d.permitted = 1'b1;
            return d;
        end
        seen = 1'b0;
        allow = 1'b0;
        for (int i = 0; i < rule_count; i++) begin
            if (rule_uuid_high[i] == req.uuid_high && rule_uuid_low[i] == req.uuid_low &&
                rule_command[i] == req.command_code) begin
                seen = 1'b1;
                if (rule_user[i] == req.user_id || rule_group[i] == req.group_id) begin
                    allow = 1'b1;
                end
                for (int k = 0; k < n_extra; k++) begin
                    if (extras[k] == rule_group[i]) begin
                        allow = 1'b1;
                    end
                end
            end
        end
        d.permitted = seen ? allow : ~strict_deny;
        return d;
    endfunction

    function automatic access_req_t make_check(input logic [63:0] uh, input logic [63:0] ul,
                                               input logic [31:0] cid, input logic [31:0] uid,
                                               input logic [31:0] gid);
        access_req_t req;
        req = '0;
        req.op = arc_pkg::CMD_CHECK;
        req.uuid_high = uh;
        req.uuid_low = ul;
        req.command_code = cid;
        req.user_id = uid;
        req.group_id = gid;
        return req;
    endfunction

    function automatic access_req_t make_insert(input logic [63:0] uh, input logic [63:0] ul,
                                                input logic [31:0] cid, input logic [31:0] uid,
                                                input logic [31:0] gid);
        access_req_t req;
        req = make_check(uh, ul, cid, uid, gid);
        req.op = arc_pkg::CMD_INSERT;
        return req;
    endfunction

    // Presents one request and records its decision once the input transfer happens.
    task automatic post_request(input access_req_t req);
        int gap;
        gap = input_gaps_on ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_decisions.push_back(decide_access(req));
    endtask

    // Lowers valid and waits until every pending decision has been returned.
    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_decisions.size() != 0) @(posedge aclk);
    endtask

    task automatic write_strict_mode(input logic value);
        wait_for_idle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        strict_deny = value;
    endtask

    // Empty table: default policy in both modes, and the override bypass.
    task automatic test_default_policy();
        access_req_t req;
        req = make_check('1, '1, '1, '1, '1);
        req.group_count = 3'd7;
        req.extra_a = '1;
        req.extra_b = '1;
        req.extra_c = '1;
        req.extra_d = '1;
        post_request(req);
        req = make_check('0, '0, '0, '0, '0);
        req.override = 1'b1;
        post_request(req);
        write_strict_mode(1'b1);
        post_request(make_check('0, '0, '0, '0, '0));
        post_request(req);
        write_strict_mode(1'b0);
    endtask

    // Matches by user, by primary group and by the first and last supplementary group slots.
    task automatic test_rule_matching();
        access_req_t req;
        post_request(make_insert('1, '1, '1, 32'h0000_0005, 32'hFFFF_FFFE));
        post_request(make_insert('0, '0, '0, '0, '0));
        // Same key again with a different user and group.
        post_request(make_insert('1, '1, '1, 32'h8000_0000, 32'h0000_1234));
        post_request(make_check('1, '1, '1, 32'h0000_0005, 32'h0000_0002));
        post_request(make_check('1, '1, '1, 32'h8000_0000, 32'h0000_0002));
        post_request(make_check('1, '1, '1, 32'h0000_0001, 32'hFFFF_FFFE));
        req = make_check('1, '1, '1, 32'h0000_0001, 32'h0000_0002);
        req.group_count = 3'd4;
        req.extra_a = 32'h0000_0003;
        req.extra_b = 32'h0000_0004;
        req.extra_c = 32'h0000_0006;
        req.extra_d = 32'h0000_1234;
        post_request(req);
        req.group_count = 3'd1;
        req.extra_a = 32'h0000_1234;
        post_request(req);
        // The matching group sits past the valid count.
        req.group_count = 3'd2;
        req.extra_a = 32'h0000_0003;
        req.extra_c = 32'h0000_1234;
        post_request(req);
        // A count above the slot number saturates, so the last slot still counts.
        req.group_count = 3'd7;
        req.extra_c = 32'h0000_0006;
        post_request(req);
        post_request(make_check('1, '1, '1, 32'h0000_0001, 32'h0000_0002));
        // Known UUID without that command falls back to the default.
        post_request(make_check('1, '1, '0, 32'h0000_0005, 32'hFFFF_FFFE));
        write_strict_mode(1'b1);
        post_request(make_check('1, '1, '0, 32'h0000_0005, 32'hFFFF_FFFE));
        post_request(make_check('1, '0, '1, 32'h0000_0005, 32'hFFFF_FFFE));
        post_request(make_check('0, '0, '0, '0, 32'h0000_0009));
        write_strict_mode(1'b0);
    endtask

    // An insert stores only the key, user and group; caller fields play no part.
    task automatic test_insert_ignores_caller_fields();
        access_req_t req;
        req = make_insert(64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_9ABC_DEF0, 32'h0000_00AA,
                          32'h0000_0077, 32'h0000_0088);
        req.override = 1'b1;
        req.group_count = 3'd7;
        req.extra_a = '1;
        req.extra_b = '1;
        req.extra_c = '1;
        req.extra_d = '1;
        post_request(req);
        req.op = arc_pkg::CMD_CHECK;
        req.override = 1'b0;
        req.user_id = 32'h0000_0001;
        req.group_id = '1;
        post_request(req);
    endtask

    function automatic access_req_t random_request();
        access_req_t req;
        int          roll;
        int          slot;
        int          insert_share;
        roll = $urandom_range(0, 99);
        insert_share = (rule_count < TABLE_DEPTH) ? 30 : 4;
        req.op = arc_pkg::CMD_CHECK;
        req.uuid_high = uuid_pool_high[$urandom_range(0, 7)];
        req.uuid_low = uuid_pool_low[$urandom_range(0, 7)];
        req.command_code = command_pool[$urandom_range(0, 3)];
        req.user_id = id_pool[$urandom_range(0, 7)];
        req.group_id = id_pool[$urandom_range(0, 7)];
        req.override = ($urandom_range(0, 99) < 8);
        req.group_count = 3'($urandom_range(0, 7));
        req.extra_a = id_pool[$urandom_range(0, 7)];
        req.extra_b = id_pool[$urandom_range(0, 7)];
        req.extra_c = id_pool[$urandom_range(0, 7)];
        req.extra_d = id_pool[$urandom_range(0, 7)];
        if (roll < 10) begin
            // Unstructured noise over every bit of every field.
            req.op = 1'($urandom);
            req.uuid_high = {$urandom, $urandom};
            req.uuid_low = {$urandom, $urandom};
            req.command_code = $urandom;
            req.user_id = $urandom;
            req.group_id = $urandom;
            req.override = 1'($urandom);
            req.extra_a = $urandom;
            req.extra_b = $urandom;
            req.extra_c = $urandom;
            req.extra_d = $urandom;
        end else if (roll < 10 + insert_share) begin
            req.op = arc_pkg::CMD_INSERT;
        end else if (rule_count > 0 && $urandom_range(0, 99) < 85) begin
            // Aim at a stored key so the rule scan has real work to do.
            slot = $urandom_range(0, rule_count - 1);
            req.uuid_high = rule_uuid_high[slot];
            req.uuid_low = rule_uuid_low[slot];
            if ($urandom_range(0, 99) < 85) begin
                req.command_code = rule_command[slot];
            end
        end
        return req;
    endfunction

    task automatic fill_value_pools();
        uuid_pool_high[0] = '1;
        uuid_pool_low[0] = '1;
        uuid_pool_high[1] = '0;
        uuid_pool_low[1] = '0;
        for (int i = 2; i < 8; i++) begin
            uuid_pool_high[i] = {$urandom, $urandom};
            uuid_pool_low[i] = {$urandom, $urandom};
        end
        command_pool[0] = '0;
        command_pool[1] = '1;
        command_pool[2] = $urandom;
        command_pool[3] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < 8; i++) begin
            id_pool[i] = $urandom;
        end
    endtask

    // Random traffic in phases that alternate the policy mode; the idling pattern is redrawn every 60 items.
    task automatic test_random_traffic();
        int mode;
        fill_value_pools();
        for (int phase = 0; phase < 4; phase++) begin
            write_strict_mode(phase[0]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 60 == 0) begin
                    mode = $urandom_range(0, 3);
                    input_gaps_on = mode[0];
                    output_stalls_on = mode[1];
                end
                post_request(random_request());
            end
        end
    endtask

    // Result side: random stall before each result transfer.
    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        forever begin
            stall = output_stalls_on ? $urandom_range(0, 15) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each result transfer with the oldest pending decision.
    always @(posedge aclk) begin
        decision_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_decisions.size() == 0) begin
                $display("%0t: result with nothing pending, permitted=%b status=%b",
                         $time, m_permitted, m_status);
                fail_count++;
            end else begin
                want = expected_decisions.pop_front();
                if (m_permitted !== want.permitted) begin
                    $display("%0t: permitted mismatch, expected %b, actual %b",
                             $time, want.permitted, m_permitted);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %b, actual %b",
                             $time, want.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("access_rule_table_checker_core verification failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        m_ready = 1'b0;
        rule_count = 0;
        strict_deny = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        input_gaps_on = 1'b1;
        output_stalls_on = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_policy();
        test_rule_matching();
        test_insert_ignores_caller_fields();
        test_random_traffic();

        // Drain, then leave room for any stray result to show up.
        wait_for_idle();
        repeat (SCAN_CYCLES + 4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("access_rule_table_checker_core verification clean");
        end else begin
            $display("access_rule_table_checker_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/arc_pkg.sv
sv/arc_rule_cell.sv
sv/access_rule_table_checker_core.sv
sv/arc_checker.sv
tb/tb.sv
